[hw/rtl/mme_pkg.sv]
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types, constants and helpers of the multicast mask expander.
// ----------------------------------------------------------------------------
package mme_pkg;

	localparam int MAX_NODES = 64;
	localparam int MASK_W    = 64;
	localparam int COORD_W   = 6;
	localparam int SIZE_W    = 7;
	localparam int TAG_W     = 16;
	localparam int SXY_W     = 2 * SIZE_W;
	localparam int PROD_W    = SXY_W + SIZE_W;
	localparam int ADDR_W    = 4;

	localparam logic [1:0] REG_SIZE_X = 2'd0;
	localparam logic [1:0] REG_SIZE_Y = 2'd1;
	localparam logic [1:0] REG_SIZE_Z = 2'd2;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4);
	localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_NODES);

	typedef struct packed {
		logic [SIZE_W-1:0] sx;
		logic [SIZE_W-1:0] sy;
		logic [SIZE_W-1:0] sz;
	} cfg_t;

	typedef struct packed {
		logic               is_mc;
		logic [MASK_W-1:0]  mask;
		logic [COORD_W-1:0] ux;
		logic [COORD_W-1:0] uy;
		logic [COORD_W-1:0] uz;
		logic [TAG_W-1:0]   tag;
	} entry_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (v > SIZE_MAX) begin
			r = SIZE_MAX;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

[hw/rtl/multicast_mask_expander.sv]
// ----------------------------------------------------------------------------
// multicast_mask_expander
// Replicates multicast messages into unicast copies, one per destination node.
// ----------------------------------------------------------------------------
// A message enters through a two-stage front end that trims the mask to the
// node count and drops multicast messages with no destination; a two-entry
// queue then feeds the replication engine, which scans one mask bit per
// cycle (stalling at a set bit while the previous copy is unpopped) and emits
// at most one copy per cycle. A multicast message holds the engine until
// its highest in-range set bit is scanned; a unicast one scans one bit. Copies
// leave in ascending node order, the final one flagged by last_copy. Sizes of
// zero count as one and sizes above 64 as 64; the node count is capped at 64.
module multicast_mask_expander (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mme_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         push,
	output logic                         full,
	input  logic                         is_multicast,
	input  logic [mme_pkg::MASK_W-1:0]   dest_mask,
	input  logic [mme_pkg::COORD_W-1:0]  uni_x,
	input  logic [mme_pkg::COORD_W-1:0]  uni_y,
	input  logic [mme_pkg::COORD_W-1:0]  uni_z,
	input  logic [mme_pkg::TAG_W-1:0]    msg_tag,
	input  logic                         pop,
	output logic                         empty,
	output logic [mme_pkg::COORD_W-1:0]  dest_x,
	output logic [mme_pkg::COORD_W-1:0]  dest_y,
	output logic [mme_pkg::COORD_W-1:0]  dest_z,
	output logic [mme_pkg::TAG_W-1:0]    out_tag,
	output logic                         last_copy
);

	mme_pkg::cfg_t   cfg;
	mme_pkg::entry_t q_wr, q_rd;
	logic            q_push, q_full, q_pop, q_empty;

	mme_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mme_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.push         (push),
		.full         (full),
		.is_multicast (is_multicast),
		.dest_mask    (dest_mask),
		.uni_x        (uni_x),
		.uni_y        (uni_y),
		.uni_z        (uni_z),
		.msg_tag      (msg_tag),
		.q_push       (q_push),
		.q_full       (q_full),
		.q_wr         (q_wr)
	);

	mme_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_push  (q_push),
		.q_wr    (q_wr),
		.q_full  (q_full),
		.q_pop   (q_pop),
		.q_rd    (q_rd),
		.q_empty (q_empty)
	);

	mme_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_rd      (q_rd),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.pop       (pop),
		.empty     (empty),
		.dest_x    (dest_x),
		.dest_y    (dest_y),
		.dest_z    (dest_z),
		.out_tag   (out_tag),
		.last_copy (last_copy)
	);

`ifndef NO_ASSERTIONS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("queue read while empty");

	a_mc_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && q_wr.is_mc) |-> (q_wr.mask != '0))
		else $error("empty multicast mask queued");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(full && q_full && !q_pop) |=> full)
		else $error("front stall released without queue space");
`endif

endmodule

[hw/rtl/mme_regs.sv]
// ----------------------------------------------------------------------------
// mme_regs
// APB register file holding the network dimensions.
// ----------------------------------------------------------------------------
module mme_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mme_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output mme_pkg::cfg_t               cfg
);

	logic [mme_pkg::SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
	logic [1:0]                 idx;
	logic                       wr;

	assign idx    = paddr[3:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= mme_pkg::SIZE_RESET;
			size_y_q <= mme_pkg::SIZE_RESET;
			size_z_q <= mme_pkg::SIZE_RESET;
		end else if (wr) begin
			unique case (idx)
				mme_pkg::REG_SIZE_X: size_x_q <= pwdata[mme_pkg::SIZE_W-1:0];
				mme_pkg::REG_SIZE_Y: size_y_q <= pwdata[mme_pkg::SIZE_W-1:0];
				mme_pkg::REG_SIZE_Z: size_z_q <= pwdata[mme_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			mme_pkg::REG_SIZE_X: prdata = 32'(size_x_q);
			mme_pkg::REG_SIZE_Y: prdata = 32'(size_y_q);
			mme_pkg::REG_SIZE_Z: prdata = 32'(size_z_q);
			default:             prdata = '0;
		endcase
	end

	assign cfg.sx = mme_pkg::clamp_size(size_x_q);
	assign cfg.sy = mme_pkg::clamp_size(size_y_q);
	assign cfg.sz = mme_pkg::clamp_size(size_z_q);

endmodule

[hw/rtl/mme_front.sv]
// ----------------------------------------------------------------------------
// mme_front
// Two-stage front end: computes the node count, trims the mask to it and
// drops multicast messages whose trimmed mask is empty.
// ----------------------------------------------------------------------------
module mme_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mme_pkg::cfg_t                cfg,
	input  logic                         push,
	output logic                         full,
	input  logic                         is_multicast,
	input  logic [mme_pkg::MASK_W-1:0]   dest_mask,
	input  logic [mme_pkg::COORD_W-1:0]  uni_x,
	input  logic [mme_pkg::COORD_W-1:0]  uni_y,
	input  logic [mme_pkg::COORD_W-1:0]  uni_z,
	input  logic [mme_pkg::TAG_W-1:0]    msg_tag,
	output logic                         q_push,
	input  logic                         q_full,
	output mme_pkg::entry_t              q_wr
);

	logic                        valid_s1_q, valid_s2_q;
	mme_pkg::entry_t             ent_s1, ent_s2;
	logic [mme_pkg::SXY_W-1:0]   sxy_s1;
	logic [mme_pkg::SIZE_W-1:0]  nodes_s2;
	logic [mme_pkg::PROD_W-1:0]  prod;
	logic [mme_pkg::SIZE_W-1:0]  nodes;
	logic [mme_pkg::MASK_W-1:0]  eff_mask;
	logic                        drop, move_s1, move_s2, s2_free, accept;

	assign drop    = ent_s2.is_mc && (eff_mask == '0);
	assign move_s2 = valid_s2_q && (drop || !q_full);
	assign s2_free = !valid_s2_q || move_s2;
	assign move_s1 = valid_s1_q && s2_free;
	assign full    = valid_s1_q && !s2_free;
	assign accept  = push && !full;
	assign q_push  = valid_s2_q && !drop && !q_full;

	assign prod  = sxy_s1 * mme_pkg::PROD_W'(cfg.sz);
	assign nodes = (prod > mme_pkg::PROD_W'(mme_pkg::MAX_NODES)) ?
		mme_pkg::SIZE_MAX : prod[mme_pkg::SIZE_W-1:0];

	always_comb begin
		for (int j = 0; j < mme_pkg::MASK_W; j++) begin
			eff_mask[j] = ent_s2.mask[j] && (mme_pkg::SIZE_W'(j) < nodes_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
			valid_s2_q <= 1'b0;
		end else begin
			valid_s1_q <= accept || (valid_s1_q && !move_s1);
			valid_s2_q <= move_s1 || (valid_s2_q && !move_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_s1.is_mc <= is_multicast;
			ent_s1.mask  <= dest_mask;
			ent_s1.ux    <= uni_x;
			ent_s1.uy    <= uni_y;
			ent_s1.uz    <= uni_z;
			ent_s1.tag   <= msg_tag;
			sxy_s1       <= cfg.sx * cfg.sy;
		end
		if (move_s1) begin
			ent_s2   <= ent_s1;
			nodes_s2 <= nodes;
		end
	end

	always_comb begin
		q_wr      = ent_s2;
		q_wr.mask = eff_mask;
	end

endmodule

[hw/rtl/mme_queue.sv]
// ----------------------------------------------------------------------------
// mme_queue
// Two-entry queue between front end and replication engine.
// ----------------------------------------------------------------------------
module mme_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_push,
	input  mme_pkg::entry_t q_wr,
	output logic            q_full,
	input  logic            q_pop,
	output mme_pkg::entry_t q_rd,
	output logic            q_empty
);

	mme_pkg::entry_t ent_q [2];
	logic            wr_ptr_q, rd_ptr_q;
	logic [1:0]      count_q;

	assign q_full  = (count_q == 2'd2);
	assign q_empty = (count_q == 2'd0);
	assign q_rd    = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (q_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({q_push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_push) begin
			ent_q[wr_ptr_q] <= q_wr;
		end
	end

endmodule

[hw/rtl/mme_back.sv]
// ----------------------------------------------------------------------------
// mme_back
// Replication engine: walks the mask one node per cycle, tracking x/y/z, and
// places each copy in the output register; a set bit waits for it to be free.
// ----------------------------------------------------------------------------
module mme_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mme_pkg::cfg_t                cfg,
	input  mme_pkg::entry_t              q_rd,
	input  logic                         q_empty,
	output logic                         q_pop,
	input  logic                         pop,
	output logic                         empty,
	output logic [mme_pkg::COORD_W-1:0]  dest_x,
	output logic [mme_pkg::COORD_W-1:0]  dest_y,
	output logic [mme_pkg::COORD_W-1:0]  dest_z,
	output logic [mme_pkg::TAG_W-1:0]    out_tag,
	output logic                         last_copy
);

	logic                        busy_q, out_valid_q;
	logic [mme_pkg::MASK_W-1:0]  mask_q;
	logic [mme_pkg::COORD_W-1:0] x_q, y_q, z_q;
	logic [mme_pkg::TAG_W-1:0]   tag_q;
	logic [mme_pkg::SIZE_W-1:0]  x_inc, y_inc;
	logic                        pop_ok, out_ready, step, emit, more;

	assign pop_ok    = pop && out_valid_q;
	assign out_ready = !out_valid_q || pop_ok;
	assign step      = busy_q && (!mask_q[0] || out_ready);
	assign emit      = busy_q && mask_q[0] && out_ready;
	assign more      = |mask_q[mme_pkg::MASK_W-1:1];
	assign q_pop     = !busy_q && !q_empty;
	assign empty     = !out_valid_q;

	assign x_inc = mme_pkg::SIZE_W'(x_q) + mme_pkg::SIZE_W'(1);
	assign y_inc = mme_pkg::SIZE_W'(y_q) + mme_pkg::SIZE_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (step) begin
				busy_q <= more;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop_ok) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			// unicast walks a single set bit at its own coordinates
			mask_q <= q_rd.is_mc ? q_rd.mask : mme_pkg::MASK_W'(1);
			x_q    <= q_rd.is_mc ? '0 : q_rd.ux;
			y_q    <= q_rd.is_mc ? '0 : q_rd.uy;
			z_q    <= q_rd.is_mc ? '0 : q_rd.uz;
			tag_q  <= q_rd.tag;
		end else if (step) begin
			mask_q <= mask_q >> 1;
			if (x_inc == cfg.sx) begin
				x_q <= '0;
				if (y_inc == cfg.sy) begin
					y_q <= '0;
					z_q <= z_q + mme_pkg::COORD_W'(1);
				end else begin
					y_q <= y_inc[mme_pkg::COORD_W-1:0];
				end
			end else begin
				x_q <= x_inc[mme_pkg::COORD_W-1:0];
			end
		end
		if (emit) begin
			dest_x    <= x_q;
			dest_y    <= y_q;
			dest_z    <= z_q;
			out_tag   <= tag_q;
			last_copy <= !more;
		end
	end

endmodule

[tb/mme_copy_checker.sv]
// ----------------------------------------------------------------------------
// mme_copy_checker
// Watches the register port and both queue sides of the mask expander, works
// out the unicast copies each accepted message must produce and compares
// every popped copy, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module mme_copy_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [mme_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	input  logic                         push,
	input  logic                         full,
	input  logic                         is_multicast,
	input  logic [mme_pkg::MASK_W-1:0]   dest_mask,
	input  logic [mme_pkg::COORD_W-1:0]  uni_x,
	input  logic [mme_pkg::COORD_W-1:0]  uni_y,
	input  logic [mme_pkg::COORD_W-1:0]  uni_z,
	input  logic [mme_pkg::TAG_W-1:0]    msg_tag,
	input  logic                         pop,
	input  logic                         empty,
	input  logic [mme_pkg::COORD_W-1:0]  dest_x,
	input  logic [mme_pkg::COORD_W-1:0]  dest_y,
	input  logic [mme_pkg::COORD_W-1:0]  dest_z,
	input  logic [mme_pkg::TAG_W-1:0]    out_tag,
	input  logic                         last_copy,
	output int                           errors,
	output int                           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import mme_pkg::*;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [TAG_W-1:0]   tag;
		logic               last;
	} copy_t;

	copy_t             copies_due[$];
	logic [SIZE_W-1:0] size_x_q;
	logic [SIZE_W-1:0] size_y_q;
	logic [SIZE_W-1:0] size_z_q;
	int                miss_cnt = 0;
	copy_t             head;

	function automatic int node_dim(input logic [SIZE_W-1:0] v);
		int d;
		d = int'(v);
		if (d == 0) begin
			d = 1;
		end else if (d > MAX_NODES) begin
			d = MAX_NODES;
		end
		return d;
	endfunction

	task automatic report_mismatch(input string what, input logic [TAG_W-1:0] got,
			input logic [TAG_W-1:0] want);
		$display("%0t: copy %s got 0x%0h, want 0x%0h", $time, what, got, want);
		miss_cnt++;
	endtask

	// one entry per set in-range mask bit, ascending; a unicast message gives one
	task automatic expand_message(input logic mc, input logic [MASK_W-1:0] mask,
			input logic [COORD_W-1:0] ux, input logic [COORD_W-1:0] uy,
			input logic [COORD_W-1:0] uz, input logic [TAG_W-1:0] tag);
		int    sx;
		int    sy;
		int    sz;
		int    nodes;
		int    hi;
		int    i;
		copy_t c;
		c.tag = tag;
		if (!mc) begin
			c.x    = ux;
			c.y    = uy;
			c.z    = uz;
			c.last = 1'b1;
			copies_due.push_back(c);
		end else begin
			sx    = node_dim(size_x_q);
			sy    = node_dim(size_y_q);
			sz    = node_dim(size_z_q);
			nodes = sx * sy * sz;
			if (nodes > MAX_NODES) begin
				nodes = MAX_NODES;
			end
			hi = -1;
			for (i = 0; i < nodes; i++) begin
				if (mask[i]) begin
					hi = i;
				end
			end
			for (i = 0; i < nodes; i++) begin
				if (mask[i]) begin
					c.x    = COORD_W'(i % sx);
					c.y    = COORD_W'((i / sx) % sy);
					c.z    = COORD_W'(i / (sx * sy));
					c.last = (i == hi);
					copies_due.push_back(c);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q = SIZE_RESET;
			size_y_q = SIZE_RESET;
			size_z_q = SIZE_RESET;
			copies_due.delete();
			pending <= 0;
			errors  <= miss_cnt;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_SIZE_X: size_x_q = pwdata[SIZE_W-1:0];
					REG_SIZE_Y: size_y_q = pwdata[SIZE_W-1:0];
					REG_SIZE_Z: size_z_q = pwdata[SIZE_W-1:0];
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (copies_due.size() == 0) begin
					report_mismatch("with none due, tag", out_tag, '0);
				end else begin
					head = copies_due.pop_front();
					if (dest_x !== head.x) report_mismatch("dest_x", dest_x, head.x);
					if (dest_y !== head.y) report_mismatch("dest_y", dest_y, head.y);
					if (dest_z !== head.z) report_mismatch("dest_z", dest_z, head.z);
					if (out_tag !== head.tag) report_mismatch("out_tag", out_tag, head.tag);
					if (last_copy !== head.last) begin
						report_mismatch("last_copy", last_copy, head.last);
					end
				end
			end
			if (push && !full) begin
				expand_message(is_multicast, dest_mask, uni_x, uni_y, uni_z, msg_tag);
			end
			pending <= copies_due.size();
			errors  <= miss_cnt;
		end
	end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives the multicast mask expander through a directed set of messages and
// then randomized phases, each under its own network size, with random gaps
// on both queue sides and one long output stall that backs up the input.
// Checking lives in mme_copy_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mme_pkg::*;

	localparam logic [1:0] REG_SPARE    = 2'd3;
	localparam int         DRAIN_CYCLES = 200;
	localparam int         HOLD_CYCLES  = 600;
	localparam int         PHASES       = 10;
	localparam int         PHASE_ITEMS  = 36;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	logic                push;
	logic                full;
	logic                is_multicast;
	logic [MASK_W-1:0]   dest_mask;
	logic [COORD_W-1:0]  uni_x;
	logic [COORD_W-1:0]  uni_y;
	logic [COORD_W-1:0]  uni_z;
	logic [TAG_W-1:0]    msg_tag;
	logic                pop;
	logic                empty;
	logic [COORD_W-1:0]  dest_x;
	logic [COORD_W-1:0]  dest_y;
	logic [COORD_W-1:0]  dest_z;
	logic [TAG_W-1:0]    out_tag;
	logic                last_copy;
	int                  errors;
	int                  pending;
	logic                no_idle;
	int                  hold_go;

	int phase_x [PHASES] = '{1, 64, 1, 1, 4, 3, 8, 5, 0, 1};
	int phase_y [PHASES] = '{1, 1, 64, 1, 4, 5, 8, 3, 127, 1};
	int phase_z [PHASES] = '{1, 1, 1, 64, 4, 2, 1, 7, 3, 1};

	multicast_mask_expander dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.push         (push),
		.full         (full),
		.is_multicast (is_multicast),
		.dest_mask    (dest_mask),
		.uni_x        (uni_x),
		.uni_y        (uni_y),
		.uni_z        (uni_z),
		.msg_tag      (msg_tag),
		.pop          (pop),
		.empty        (empty),
		.dest_x       (dest_x),
		.dest_y       (dest_y),
		.dest_z       (dest_z),
		.out_tag      (out_tag),
		.last_copy    (last_copy)
	);

	mme_copy_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.push         (push),
		.full         (full),
		.is_multicast (is_multicast),
		.dest_mask    (dest_mask),
		.uni_x        (uni_x),
		.uni_y        (uni_y),
		.uni_z        (uni_z),
		.msg_tag      (msg_tag),
		.pop          (pop),
		.empty        (empty),
		.dest_x       (dest_x),
		.dest_y       (dest_y),
		.dest_z       (dest_z),
		.out_tag      (out_tag),
		.last_copy    (last_copy),
		.errors       (errors),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_sizes(input int sx, input int sy, input int sz);
		logic [31:0] v;
		v = $urandom();
		v[SIZE_W-1:0] = SIZE_W'(sx);
		reg_write(REG_SIZE_X, v);
		v = $urandom();
		v[SIZE_W-1:0] = SIZE_W'(sy);
		reg_write(REG_SIZE_Y, v);
		v = $urandom();
		v[SIZE_W-1:0] = SIZE_W'(sz);
		reg_write(REG_SIZE_Z, v);
	endtask

	task automatic send_msg(input logic mc, input logic [MASK_W-1:0] m,
			input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [COORD_W-1:0] z, input logic [TAG_W-1:0] t);
		if (!no_idle && $urandom_range(99) < 16) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		push         <= 1'b1;
		is_multicast <= mc;
		dest_mask    <= m;
		uni_x        <= x;
		uni_y        <= y;
		uni_z        <= z;
		msg_tag      <= t;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic send_random();
		logic [MASK_W-1:0] m;
		m = {$urandom(), $urandom()};
		if ($urandom_range(99) < 30) begin
			send_msg(1'b0, m, COORD_W'($urandom()), COORD_W'($urandom()),
				COORD_W'($urandom()), TAG_W'($urandom()));
		end else begin
			case ($urandom_range(7))
				0: m = MASK_W'(1) << $urandom_range(63);
				1: m = '1;
				2: m = m & {$urandom(), $urandom()} & {$urandom(), $urandom()};
				3: m = m | {$urandom(), $urandom()};
				4: m = m >> $urandom_range(63);
				5: m = m << $urandom_range(63);
				default: ;
			endcase
			if ($urandom_range(49) == 0) begin
				m = '0;
			end
			send_msg(1'b1, m, COORD_W'($urandom()), COORD_W'($urandom()),
				COORD_W'($urandom()), TAG_W'($urandom()));
		end
	endtask

	// wait out every due copy, then the engine's longest scan
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int served;
		served = 0;
		pop    = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go != served) begin
				served++;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				pop <= no_idle || ($urandom_range(99) >= 16);
			end
		end
	end

	initial begin
		int ph;
		int n;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		push         = 1'b0;
		is_multicast = 1'b0;
		dest_mask    = '0;
		uni_x        = '0;
		uni_y        = '0;
		uni_z        = '0;
		msg_tag      = '0;
		no_idle      = 1'b0;
		hold_go      = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes, 64 nodes
		send_msg(1'b0, '1, 6'd0, 6'd0, 6'd0, 16'h0000);
		send_msg(1'b0, '0, 6'd63, 6'd63, 6'd63, 16'hFFFF);
		send_msg(1'b1, '0, 6'd1, 6'd2, 6'd3, 16'h0001);
		send_msg(1'b1, '1, 6'd63, 6'd63, 6'd63, 16'h8000);
		send_msg(1'b1, 64'h1, 6'd0, 6'd0, 6'd0, 16'h1234);
		send_msg(1'b1, 64'h8000_0000_0000_0000, 6'd7, 6'd7, 6'd7, 16'h4321);
		send_msg(1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 6'h2A, 6'h2A, 6'h2A, 16'hAAAA);
		send_msg(1'b1, 64'h5555_5555_5555_5555, 6'h15, 6'h15, 6'h15, 16'h5555);
		send_msg(1'b0, 64'h5555_5555_5555_5555, 6'h2A, 6'h15, 6'h2A, 16'h5A5A);
		settle();
		// 8 nodes: bits above the node count drop out
		set_sizes(2, 2, 2);
		send_msg(1'b1, 64'hFFFF_FFFF_FFFF_FF00, 6'd1, 6'd1, 6'd1, 16'h0F0F);
		send_msg(1'b1, 64'h0000_0000_0000_0180, 6'd2, 6'd2, 6'd2, 16'hF0F0);
		send_msg(1'b1, '1, 6'd3, 6'd3, 6'd3, 16'h00FF);
		send_msg(1'b0, '1, 6'd5, 6'd6, 6'd7, 16'hFF00);
		settle();
		// zero sizes count as one
		set_sizes(0, 0, 0);
		send_msg(1'b1, '1, 6'd9, 6'd9, 6'd9, 16'h0002);
		send_msg(1'b1, 64'hFFFF_FFFF_FFFF_FFFE, 6'd9, 6'd9, 6'd9, 16'h0003);
		send_msg(1'b1, 64'h1, 6'd9, 6'd9, 6'd9, 16'h0004);
		settle();
		// oversized registers saturate
		set_sizes(127, 127, 127);
		send_msg(1'b1, '1, 6'd0, 6'd0, 6'd0, 16'h0005);
		send_msg(1'b1, 64'h8000_0000_0000_0001, 6'd0, 6'd0, 6'd0, 16'h0006);
		send_msg(1'b0, '0, 6'd33, 6'd17, 6'd48, 16'h0007);

		for (ph = 0; ph < PHASES; ph++) begin
			settle();
			if (ph == PHASES - 1) begin
				phase_x[ph] = $urandom_range(0, 127);
				phase_y[ph] = $urandom_range(0, 127);
				phase_z[ph] = $urandom_range(0, 127);
			end
			set_sizes(phase_x[ph], phase_y[ph], phase_z[ph]);
			if (ph == 3) begin
				reg_write(REG_SPARE, $urandom());
			end
			if (ph == 4) begin
				hold_go <= hold_go + 1;
			end
			no_idle <= (ph == 6);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				send_random();
			end
		end
		settle();

		if (errors == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

[multicast_mask_expander.f]
hw/rtl/mme_pkg.sv
hw/rtl/mme_regs.sv
hw/rtl/mme_front.sv
hw/rtl/mme_queue.sv
hw/rtl/mme_back.sv
hw/rtl/multicast_mask_expander.sv
tb/mme_copy_checker.sv
tb/tb_top.sv
